/* rtl/chm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Operation and status codes shared by the hash map and its checker.
// ----------------------------------------------------------------------------
package chm_pkg;

  typedef enum logic [1:0] {
    KIND_SEARCH = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_DUP_KEY  = 2'd2,
    STAT_POOL_FULL = 2'd3
  } status_t;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

endpackage

/* rtl/chm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/chained_hash_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map
// Key-to-data map as a hash table with separate chaining over a node pool.
// ----------------------------------------------------------------------------
// Usage:
//   Drive kind/key/value and raise start while busy is low; that edge takes
//   the transaction. busy stays high until the result is out. The result
//   (status, found_value) shows for exactly one cycle with done high; the
//   receiver cannot stall it and must take it then.
// Flow: S_MOD when BUCKETS is not a power of two (the bucket modulo runs
//   a 4-bit-per-cycle reduction over the key), then S_HREAD, S_HDATA, one
//   S_NDATA per node walked in the bucket, then S_DECIDE; an insert via the
//   free list adds S_FDATA and a delete hit adds S_DEL2.
// One transaction at a time; the next one can start in the done cycle. The
// rate is set by the chain walk: one node memory read per node.
// Reset: after rst falls, a clearing pass writes every bucket head to null,
//   one bucket per cycle, with busy held high.
// ----------------------------------------------------------------------------
module chained_hash_map #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [chm_pkg::KEY_W-1:0] key,
  input  logic [chm_pkg::VAL_W-1:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [chm_pkg::VAL_W-1:0] found_value
);
  import chm_pkg::*;

  localparam int  LW   = $clog2(NODES + 1);            // pointer, NODES is null
  localparam int  AW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int  BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int  RW   = $clog2(BUCKETS) + 2;          // modulo remainder
  localparam int  NW   = KEY_W + VAL_W + LW;           // node word
  localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [LW-1:0] NIL = LW'(NODES);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_MOD    = 9'b000000100,
    S_HREAD  = 9'b000001000,
    S_HDATA  = 9'b000010000,
    S_NDATA  = 9'b000100000,
    S_DECIDE = 9'b001000000,
    S_FDATA  = 9'b010000000,
    S_DEL2   = 9'b100000000
  } state_t;

  state_t state;

  // Latched transaction
  logic [1:0]       kind_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic [BW-1:0]    bucket;

  // Modulo unit
  logic [KEY_W-1:0] mkey;
  logic [2:0]       mcnt;
  logic [RW-1:0]    mrem;
  logic [RW-1:0]    mstep;

  // Chain walk
  logic [LW-1:0]    hd;
  logic [LW-1:0]    cur;
  logic [LW-1:0]    prev;
  logic [LW-1:0]    steps;
  logic [LW-1:0]    steps_next;
  logic             hit;
  logic [LW-1:0]    hit_ptr;
  logic [LW-1:0]    hit_link;
  logic [KEY_W+VAL_W-1:0] hit_kv;
  logic [KEY_W+VAL_W-1:0] prev_kv;

  // Pool bookkeeping
  logic [LW-1:0]    free_head;
  logic [LW-1:0]    unused_count;
  logic [BW-1:0]    clr_cnt;

  // Memory ports
  logic             head_we;
  logic [BW-1:0]    head_waddr;
  logic [LW-1:0]    head_wdata;
  logic [LW-1:0]    head_rdata;
  logic             node_we;
  logic [AW-1:0]    node_waddr;
  logic [NW-1:0]    node_wdata;
  logic [AW-1:0]    node_raddr;
  logic [NW-1:0]    node_rdata;

  logic [KEY_W-1:0] nd_key;
  logic [VAL_W-1:0] nd_val;
  logic [LW-1:0]    nd_link;

  assign nd_key  = node_rdata[NW-1 -: KEY_W];
  assign nd_val  = node_rdata[LW +: VAL_W];
  assign nd_link = node_rdata[LW-1:0];

  assign busy       = (state != S_IDLE);
  assign steps_next = steps + LW'(1);

  chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (bucket),
    .rdata (head_rdata)
  );

  chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Four restoring steps of key mod BUCKETS, most significant nibble first
  always_comb begin
    mstep = mrem;
    for (int i = 0; i < 4; i++) begin
      mstep = {mstep[RW-2:0], mkey[KEY_W-1-i]};
      if (mstep >= RW'(BUCKETS)) begin
        mstep = mstep - RW'(BUCKETS);
      end
    end
  end

  // Memory port steering
  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = NIL;
    node_we    = 1'b0;
    node_waddr = free_head[AW-1:0];
    node_wdata = {key_q, value_q, hd};
    node_raddr = cur[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt;
      end
      S_HDATA:  node_raddr = head_rdata[AW-1:0];
      S_NDATA:  node_raddr = nd_link[AW-1:0];
      S_DECIDE: begin
        node_raddr = free_head[AW-1:0];
        if (kind_q == KIND_INSERT && !hit && free_head == NIL &&
            unused_count < NIL) begin
          // Take the next never-used node
          node_we    = 1'b1;
          node_waddr = unused_count[AW-1:0];
          head_we    = 1'b1;
          head_wdata = unused_count;
        end else if (kind_q == KIND_DELETE && hit) begin
          // Unlink the hit node from its predecessor or the bucket head
          if (prev != NIL) begin
            node_we    = 1'b1;
            node_waddr = prev[AW-1:0];
            node_wdata = {prev_kv, hit_link};
          end else begin
            head_we    = 1'b1;
            head_wdata = hit_link;
          end
        end
      end
      S_FDATA: begin
        node_we    = 1'b1;
        head_we    = 1'b1;
        head_wdata = free_head;
      end
      S_DEL2: begin
        node_we    = 1'b1;
        node_waddr = hit_ptr[AW-1:0];
        node_wdata = {hit_kv, free_head};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      free_head    <= NIL;
      unused_count <= '0;
      done         <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          done    <= 1'b0;
          clr_cnt <= clr_cnt + BW'(1);
          if (clr_cnt == BW'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            kind_q  <= kind;
            key_q   <= key;
            value_q <= value;
            mkey    <= key;
            mrem    <= '0;
            mcnt    <= '0;
            if (POW2) begin
              bucket <= BW'(key & KEY_W'(BUCKETS - 1));
              state  <= S_HREAD;
            end else begin
              state  <= S_MOD;
            end
          end
        end
        S_MOD: begin
          done <= 1'b0;
          mrem <= mstep;
          mkey <= mkey << 4;
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd7) begin
            bucket <= mstep[BW-1:0];
            state  <= S_HREAD;
          end
        end
        S_HREAD: begin
          done  <= 1'b0;
          state <= S_HDATA;
        end
        S_HDATA: begin
          done  <= 1'b0;
          hd    <= head_rdata;
          cur   <= head_rdata;
          prev  <= NIL;
          steps <= '0;
          hit   <= 1'b0;
          state <= (head_rdata >= NIL) ? S_DECIDE : S_NDATA;
        end
        S_NDATA: begin
          done <= 1'b0;
          if (nd_key == key_q) begin
            hit      <= 1'b1;
            hit_ptr  <= cur;
            hit_link <= nd_link;
            hit_kv   <= {nd_key, nd_val};
            state    <= S_DECIDE;
          end else begin
            // Advance to the next node, or stop at the chain end or once NODES nodes are walked
            prev    <= cur;
            prev_kv <= {nd_key, nd_val};
            cur     <= nd_link;
            steps   <= steps_next;
            if (nd_link >= NIL || steps_next == NIL) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          found_value <= (kind_q == KIND_SEARCH && hit) ? hit_kv[VAL_W-1:0] : '0;
          unique case (kind_q)
            KIND_SEARCH: begin
              status <= hit ? STAT_OK : STAT_NOT_FOUND;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
            KIND_INSERT: begin
              if (hit) begin
                status <= STAT_DUP_KEY;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if (free_head != NIL) begin
                // Pop the free list: its link arrives next cycle
                done  <= 1'b0;
                state <= S_FDATA;
              end else if (unused_count < NIL) begin
                unused_count <= unused_count + LW'(1);
                status       <= STAT_OK;
                done         <= 1'b1;
                state        <= S_IDLE;
              end else begin
                status <= STAT_POOL_FULL;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            KIND_DELETE: begin
              if (hit) begin
                done  <= 1'b0;
                state <= S_DEL2;
              end else begin
                status <= STAT_NOT_FOUND;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            default: begin
              status <= STAT_NOT_FOUND;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          endcase
        end
        S_FDATA: begin
          free_head   <= (nd_link > NIL) ? NIL : nd_link;
          status      <= STAT_OK;
          found_value <= '0;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        S_DEL2: begin
          free_head   <= hit_ptr;
          status      <= STAT_OK;
          found_value <= '0;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/chm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks on the hash map's command and result behavior.
// ----------------------------------------------------------------------------
module chm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] found_value
);
  import chm_pkg::*;

  // Reset always begins the bucket clearing pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // A taken transaction holds the block busy
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after transaction taken");

  // A result closes the transaction: block is free when done shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done outside end of transaction");

  // Only a successful search carries data; here failed results must show zero
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != STAT_OK |-> found_value == 32'd0)
    else $error("found_value nonzero on failure");

endmodule

bind chained_hash_map chm_checker u_chm_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .found_value (found_value)
);
